[design/pmi_pkg.sv]
// ----------------------------------------------------------------------------
// pmi_pkg: shared types and tables for the polar motion integrator
// Holds the transaction structs, the sine table sizing and the quarter-wave
// sine table. The table is built at elaboration.
// ----------------------------------------------------------------------------
package pmi_pkg;

	// Sine table sizing: entries per full circle is 2**SIN_BITS
	localparam int SIN_BITS = 10;
	localparam int QTR      = 1 << (SIN_BITS - 2);

	// Quarter-wave polynomial coefficients, Q16
	localparam longint unsigned SIN_A = 102943;
	localparam longint unsigned SIN_B = 42047;
	localparam longint unsigned SIN_C = 4640;

	// Rounding constant for a Q1.14 product
	localparam int ROUND_Q14 = 8192;

	typedef struct packed {
		logic signed [23:0] pos_x;
		logic signed [23:0] pos_y;
		logic        [15:0] heading;
		logic signed [15:0] speed_now;
		logic signed [15:0] accel;
		logic signed [15:0] turn_rate;
		logic signed [15:0] speed_ceiling;
		logic signed [15:0] speed_floor;
		logic               ceiling_on;
		logic               floor_on;
	} motion_in_t;

	typedef struct packed {
		logic signed [23:0] new_pos_x;
		logic signed [23:0] new_pos_y;
		logic        [15:0] new_heading;
		logic signed [15:0] speed_next;
		logic signed [15:0] vel_x;
		logic signed [15:0] vel_y;
	} motion_out_t;

	// One trig lookup result: Q1.14 magnitude and its sign
	typedef struct packed {
		logic [14:0] mag;
		logic        neg;
	} trig_t;

	typedef logic [14:0] qsin_tab_t [QTR+1];

	function automatic qsin_tab_t build_qsin();
		qsin_tab_t        tab;
		longint unsigned  t;
		longint unsigned  t2;
		longint unsigned  r1;
		longint unsigned  r3;
		longint unsigned  s;
		for (int x = 0; x <= QTR; x++) begin
			t      = longint'(x) << (18 - SIN_BITS);
			t2     = (t * t) >> 16;
			r1     = SIN_B - ((SIN_C * t2) >> 16);
			r3     = SIN_A - ((t2 * r1) >> 16);
			s      = (t * r3) >> 16;
			tab[x] = 15'((s + 2) >> 2);
		end
		return tab;
	endfunction

	localparam qsin_tab_t QSIN = build_qsin();

endpackage

[design/pmi_sincos.sv]
// ----------------------------------------------------------------------------
// pmi_sincos: sine and cosine lookup
// Folds a table index onto the quarter wave and reads both components.
// ----------------------------------------------------------------------------
module pmi_sincos
	import pmi_pkg::*;
(
	input  logic [SIN_BITS-1:0] idx,
	output trig_t               sin_v,
	output trig_t               cos_v
);

	logic [SIN_BITS-1:0] k_cos;
	logic [1:0]          quad_s;
	logic [1:0]          quad_c;
	logic [SIN_BITS-2:0] qi_s;
	logic [SIN_BITS-2:0] qi_c;

	// cosine is the sine a quarter circle on
	assign k_cos  = idx + SIN_BITS'(QTR);
	assign quad_s = idx[SIN_BITS-1 -: 2];
	assign quad_c = k_cos[SIN_BITS-1 -: 2];

	// mirror the index in the odd quadrants
	assign qi_s = quad_s[0] ? (SIN_BITS-1)'(QTR) - {1'b0, idx[SIN_BITS-3:0]}
	                        : {1'b0, idx[SIN_BITS-3:0]};
	assign qi_c = quad_c[0] ? (SIN_BITS-1)'(QTR) - {1'b0, k_cos[SIN_BITS-3:0]}
	                        : {1'b0, k_cos[SIN_BITS-3:0]};

	assign sin_v = '{mag: QSIN[qi_s], neg: quad_s[1]};
	assign cos_v = '{mag: QSIN[qi_c], neg: quad_c[1]};

endmodule

[design/polar_motion_integrator.sv]
// ----------------------------------------------------------------------------
// polar_motion_integrator: one Euler tick for an object with polar velocity
// Pipeline: six register stages, s1 to s6; a request is registered into s1
// when it is accepted, and its result is presented on rsp from s6.
// Throughput: one transaction per cycle while rsp is not stalled.
// Each stage advances when it is empty or the stage after it advances, so
// bubbles close up and a stalled result holds in the last stage.
// Reset clears every stage valid bit; payload registers are not reset.
// ----------------------------------------------------------------------------
module polar_motion_integrator
	import pmi_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        req_valid,
	output logic        req_stall,
	input  motion_in_t  req,
	output logic        rsp_valid,
	input  logic        rsp_stall,
	output motion_out_t rsp
);

	// Stage enables: a stage loads when it is empty or its successor loads
	logic en1, en2, en3, en4, en5, en6;
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;

	assign en6 = !v_s6 || !rsp_stall;
	assign en5 = !v_s5 || en6;
	assign en4 = !v_s4 || en5;
	assign en3 = !v_s3 || en4;
	assign en2 = !v_s2 || en3;
	assign en1 = !v_s1 || en2;

	assign req_stall = !en1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else begin
			if (en1) v_s1 <= req_valid;
			if (en2) v_s2 <= v_s1;
			if (en3) v_s3 <= v_s2;
			if (en4) v_s4 <= v_s3;
			if (en5) v_s5 <= v_s4;
			if (en6) v_s6 <= v_s5;
		end
	end

	// ------------------------------------------------------------------
	// Stage 1: turn the heading, add the acceleration with saturation,
	// flip the heading by half a circle on a sign reversal
	// ------------------------------------------------------------------
	logic signed [16:0] spd_sum;
	logic signed [15:0] spd_sat;
	logic               flip;
	logic [15:0]        ang_turn;

	assign spd_sum  = 17'(req.speed_now) + 17'(req.accel);
	assign spd_sat  = (spd_sum > 17'sd32767)  ? 16'sh7fff :
	                  (spd_sum < -17'sd32768) ? 16'sh8000 : spd_sum[15:0];
	assign flip     = (req.speed_now < 0 && spd_sat > 0) ||
	                  (req.speed_now > 0 && spd_sat < 0);
	assign ang_turn = req.heading + 16'(req.turn_rate);

	logic signed [23:0] px_s1, py_s1;
	logic [15:0]        ang_s1;
	logic signed [15:0] ns_s1, ceil_s1, floor_s1;
	logic               ceil_on_s1, floor_on_s1;

	always_ff @(posedge clk) begin
		if (en1) begin
			px_s1       <= req.pos_x;
			py_s1       <= req.pos_y;
			ang_s1      <= {ang_turn[15] ^ flip, ang_turn[14:0]};
			ns_s1       <= spd_sat;
			ceil_s1     <= req.speed_ceiling;
			floor_s1    <= req.speed_floor;
			ceil_on_s1  <= req.ceiling_on;
			floor_on_s1 <= req.floor_on;
		end
	end

	// ------------------------------------------------------------------
	// Stage 2: ceiling then floor clamp, so the floor wins when crossed;
	// take the magnitude (full 32768 for the most negative speed)
	// ------------------------------------------------------------------
	logic signed [15:0] ns_ceil, ns_clamp;
	logic [15:0]        mag_c;

	assign ns_ceil  = (ceil_on_s1 && ns_s1 > ceil_s1) ? ceil_s1 : ns_s1;
	assign ns_clamp = (floor_on_s1 && ns_ceil < floor_s1) ? floor_s1 : ns_ceil;
	assign mag_c    = ns_clamp[15] ? 16'(-ns_clamp) : 16'(ns_clamp);

	logic signed [23:0] px_s2, py_s2;
	logic [15:0]        ang_s2;
	logic signed [15:0] ns_s2;
	logic [15:0]        mag_s2;

	always_ff @(posedge clk) begin
		if (en2) begin
			px_s2  <= px_s1;
			py_s2  <= py_s1;
			ang_s2 <= ang_s1;
			ns_s2  <= ns_clamp;
			mag_s2 <= mag_c;
		end
	end

	// ------------------------------------------------------------------
	// Stage 3: table lookup for sine and cosine of the final heading
	// ------------------------------------------------------------------
	trig_t sin_c, cos_c;

	pmi_sincos u_sincos (
		.idx   (ang_s2[15 -: SIN_BITS]),
		.sin_v (sin_c),
		.cos_v (cos_c)
	);

	logic signed [23:0] px_s3, py_s3;
	logic [15:0]        ang_s3;
	logic signed [15:0] ns_s3;
	logic [15:0]        mag_s3;
	trig_t              sin_s3, cos_s3;

	always_ff @(posedge clk) begin
		if (en3) begin
			px_s3  <= px_s2;
			py_s3  <= py_s2;
			ang_s3 <= ang_s2;
			ns_s3  <= ns_s2;
			mag_s3 <= mag_s2;
			sin_s3 <= sin_c;
			cos_s3 <= cos_c;
		end
	end

	// ------------------------------------------------------------------
	// Stage 4: scale the magnitude by each component, round to Q8.8
	// ------------------------------------------------------------------
	logic [30:0] prod_x, prod_y, rnd_x, rnd_y;

	assign prod_x = 31'(mag_s3) * 31'(cos_s3.mag);
	assign prod_y = 31'(mag_s3) * 31'(sin_s3.mag);
	assign rnd_x  = prod_x + 31'(ROUND_Q14);
	assign rnd_y  = prod_y + 31'(ROUND_Q14);

	logic signed [23:0] px_s4, py_s4;
	logic [15:0]        ang_s4;
	logic signed [15:0] ns_s4;
	logic [15:0]        pmx_s4, pmy_s4;
	logic               negx_s4, negy_s4;

	always_ff @(posedge clk) begin
		if (en4) begin
			px_s4   <= px_s3;
			py_s4   <= py_s3;
			ang_s4  <= ang_s3;
			ns_s4   <= ns_s3;
			pmx_s4  <= rnd_x[29:14];
			pmy_s4  <= rnd_y[29:14];
			negx_s4 <= cos_s3.neg;
			negy_s4 <= sin_s3.neg;
		end
	end

	// ------------------------------------------------------------------
	// Stage 5: apply the sign and saturate the velocity to 16 bits
	// ------------------------------------------------------------------
	logic signed [16:0] vsx, vsy;
	logic signed [15:0] vx_c, vy_c;

	assign vsx  = negx_s4 ? -signed'({1'b0, pmx_s4}) : signed'({1'b0, pmx_s4});
	assign vsy  = negy_s4 ? -signed'({1'b0, pmy_s4}) : signed'({1'b0, pmy_s4});
	assign vx_c = (vsx > 17'sd32767) ? 16'sh7fff : vsx[15:0];
	assign vy_c = (vsy > 17'sd32767) ? 16'sh7fff : vsy[15:0];

	logic signed [23:0] px_s5, py_s5;
	logic [15:0]        ang_s5;
	logic signed [15:0] ns_s5;
	logic signed [15:0] vx_s5, vy_s5;

	always_ff @(posedge clk) begin
		if (en5) begin
			px_s5  <= px_s4;
			py_s5  <= py_s4;
			ang_s5 <= ang_s4;
			ns_s5  <= ns_s4;
			vx_s5  <= vx_c;
			vy_s5  <= vy_c;
		end
	end

	// ------------------------------------------------------------------
	// Stage 6: advance the position and saturate to 24 bits; this stage
	// is the output register and holds while rsp is stalled
	// ------------------------------------------------------------------
	logic signed [24:0] sum_x, sum_y;
	logic signed [23:0] nx_c, ny_c;

	assign sum_x = 25'(px_s5) + 25'(vx_s5);
	assign sum_y = 25'(py_s5) + 25'(vy_s5);
	assign nx_c  = (sum_x[24] != sum_x[23]) ? (sum_x[24] ? 24'sh800000 : 24'sh7fffff)
	                                        : sum_x[23:0];
	assign ny_c  = (sum_y[24] != sum_y[23]) ? (sum_y[24] ? 24'sh800000 : 24'sh7fffff)
	                                        : sum_y[23:0];

	motion_out_t out_s6;

	always_ff @(posedge clk) begin
		if (en6) begin
			out_s6.new_pos_x   <= nx_c;
			out_s6.new_pos_y   <= ny_c;
			out_s6.new_heading <= ang_s5;
			out_s6.speed_next  <= ns_s5;
			out_s6.vel_x       <= vx_s5;
			out_s6.vel_y       <= vy_s5;
		end
	end

	assign rsp_valid = v_s6;
	assign rsp       = out_s6;

endmodule

[design/pmi_checker.sv]
// ----------------------------------------------------------------------------
// pmi_checker: port-level checks for the polar motion integrator
// Tracks transactions in flight and checks the result channel over time.
// ----------------------------------------------------------------------------
module pmi_checker
	import pmi_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        req_valid,
	input logic        req_stall,
	input logic        rsp_valid,
	input logic        rsp_stall,
	input motion_out_t rsp
);

	localparam int DEPTH = 6;

	logic       req_acc, rsp_acc;
	logic [3:0] inflight_q;
	logic [15:0] spd_mag, vx_mag, vy_mag;

	assign req_acc = req_valid && !req_stall;
	assign rsp_acc = rsp_valid && !rsp_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inflight_q <= '0;
		end else begin
			inflight_q <= inflight_q + 4'(req_acc) - 4'(rsp_acc);
		end
	end

	assign spd_mag = rsp.speed_next[15] ? 16'(-rsp.speed_next) : 16'(rsp.speed_next);
	assign vx_mag  = rsp.vel_x[15] ? 16'(-rsp.vel_x) : 16'(rsp.vel_x);
	assign vy_mag  = rsp.vel_y[15] ? 16'(-rsp.vel_y) : 16'(rsp.vel_y);

	// a stalled result holds
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
		else $error("result changed while stalled");

	// never more transactions in flight than pipeline stages
	a_depth: assert property (@(posedge clk) disable iff (!arst_n)
		inflight_q <= 4'(DEPTH))
		else $error("too many transactions in flight");

	// no result without a request behind it
	a_no_phantom: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> inflight_q != 4'd0)
		else $error("result without a request");

	// velocity components never exceed the speed magnitude
	a_vel_bound: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (vx_mag <= spd_mag) && (vy_mag <= spd_mag))
		else $error("velocity exceeds speed");

endmodule

bind polar_motion_integrator pmi_checker u_pmi_checker (.*);

[bench/tb_polar_motion_integrator.sv]
// ----------------------------------------------------------------------------
// tb_polar_motion_integrator: self-checking bench for the polar motion integrator
// Streams single-tick motion transactions into the block and predicts each
// result independently: heading update, saturating speed with reversal and
// clamps, table-based velocity and saturating position. A directed set covers
// the field extremes and corner cases. Random traffic follows under three
// idling patterns on the request and response sides.
// ----------------------------------------------------------------------------
module tb_polar_motion_integrator
	import pmi_pkg::*;
();

	timeunit 1ns;
	timeprecision 1ps;

	// Sine table geometry used by the predictor: 2**TRIG_IDX_BITS entries per turn
	localparam int              TRIG_IDX_BITS = SIN_BITS;
	localparam int unsigned     TRIG_ENTRIES  = 1 << TRIG_IDX_BITS;
	localparam int unsigned     TRIG_QUARTER  = TRIG_ENTRIES / 4;
	localparam longint unsigned POLY_A        = 102943;
	localparam longint unsigned POLY_B        = 42047;
	localparam longint unsigned POLY_C        = 4640;

	// Cycles without any transaction on either side before the run is abandoned
	localparam int QUIET_LIMIT = 2000;
	// Extra cycles to watch for stray results once everything has arrived
	localparam int DRAIN_CYCLES = 12;

	logic        clk;
	logic        arst_n;
	logic        req_valid;
	logic        req_stall;
	motion_in_t  req;
	logic        rsp_valid;
	logic        rsp_stall = 1'b0;
	motion_out_t rsp;

	// Predicted results, oldest first
	motion_out_t motion_expected[$];

	int send_idle_pct;
	int recv_idle_pct;
	int quiet_cycles   = 0;
	int mismatch_count = 0;
	int accepted_count = 0;
	int checked_count  = 0;
	int reversal_count = 0;
	int clamp_count    = 0;
	int pos_sat_count  = 0;

	polar_motion_integrator DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// ------------------------------------------------------------------
	// Prediction
	// ------------------------------------------------------------------

	function automatic longint clip(longint v, longint lo, longint hi);
		return (v < lo) ? lo : ((v > hi) ? hi : v);
	endfunction

	// First quadrant of the sine, Q1.14, for step 0..TRIG_QUARTER
	function automatic int quarter_wave(int unsigned step);
		longint unsigned t;
		longint unsigned t2;
		longint unsigned r1;
		longint unsigned r3;
		longint unsigned s;
		t  = longint'(step) << (18 - TRIG_IDX_BITS);
		t2 = (t * t) >> 16;
		r1 = POLY_B - ((POLY_C * t2) >> 16);
		r3 = POLY_A - ((t2 * r1) >> 16);
		s  = (t * r3) >> 16;
		return int'((s + 2) >> 2);
	endfunction

	// Full-circle sine entry by symmetry; odd quadrants mirror, upper half negates
	function automatic int trig_entry(int unsigned k);
		int unsigned slot;
		int unsigned quadrant;
		int          v;
		slot     = k % TRIG_ENTRIES;
		quadrant = slot / TRIG_QUARTER;
		if (quadrant % 2 == 1) begin
			v = quarter_wave(TRIG_QUARTER - slot % TRIG_QUARTER);
		end else begin
			v = quarter_wave(slot % TRIG_QUARTER);
		end
		return (quadrant >= 2) ? -v : v;
	endfunction

	// Magnitude times a Q1.14 factor, rounded half away from zero, saturated
	function automatic longint scale_by_trig(int unsigned mag, int trig);
		longint prod;
		prod = (longint'(mag) * longint'(trig < 0 ? -trig : trig) + 8192) >> 14;
		return clip(trig < 0 ? -prod : prod, -32768, 32767);
	endfunction

	function automatic motion_out_t predict_motion(motion_in_t m);
		motion_out_t r;
		logic [15:0] dir;
		int          spd_old;
		int          spd;
		int unsigned mag;
		int unsigned idx;
		longint      vx;
		longint      vy;
		longint      px_raw;
		longint      py_raw;
		// Turn first, wrapping round the full circle
		dir     = m.heading + m.turn_rate;
		spd_old = m.speed_now;
		spd     = int'(clip(spd_old + int'(m.accel), -32768, 32767));
		// A strict sign change of the speed flips the heading by half a turn
		if ((spd_old < 0 && spd > 0) || (spd_old > 0 && spd < 0)) begin
			dir = dir + 16'h8000;
			reversal_count++;
		end
		// Ceiling first, then floor, so crossed limits leave the floor in charge
		if (m.ceiling_on && spd > int'(m.speed_ceiling)) begin
			spd = m.speed_ceiling;
			clamp_count++;
		end
		if (m.floor_on && spd < int'(m.speed_floor)) begin
			spd = m.speed_floor;
			clamp_count++;
		end
		mag    = (spd < 0) ? -spd : spd;
		idx    = dir >> (16 - TRIG_IDX_BITS);
		vx     = scale_by_trig(mag, trig_entry(idx + TRIG_QUARTER));
		vy     = scale_by_trig(mag, trig_entry(idx));
		px_raw = longint'(m.pos_x) + vx;
		py_raw = longint'(m.pos_y) + vy;
		if (px_raw != clip(px_raw, -8388608, 8388607)) pos_sat_count++;
		if (py_raw != clip(py_raw, -8388608, 8388607)) pos_sat_count++;
		r.new_pos_x   = 24'(clip(px_raw, -8388608, 8388607));
		r.new_pos_y   = 24'(clip(py_raw, -8388608, 8388607));
		r.new_heading = dir;
		r.speed_next  = 16'(spd);
		r.vel_x       = 16'(vx);
		r.vel_y       = 16'(vy);
		return r;
	endfunction

	// ------------------------------------------------------------------
	// Checking: record accepted requests and compare every accepted result
	// ------------------------------------------------------------------

	task automatic compare_field(string name, logic signed [63:0] want,
			logic signed [63:0] got);
		if (want !== got) begin
			$error("%s: expected %0d, actual %0d", name, want, got);
			mismatch_count++;
		end
	endtask

	always @(posedge clk) begin : result_monitor
		motion_out_t want;
		logic        req_taken;
		logic        rsp_taken;
		req_taken = req_valid && !req_stall;
		rsp_taken = rsp_valid && !rsp_stall;
		// Queue the prediction before looking at the result side of this edge
		if (req_taken) begin
			motion_expected.push_back(predict_motion(req));
			accepted_count++;
		end
		if (rsp_taken) begin
			if (motion_expected.size() == 0) begin
				$error("result transaction with nothing outstanding");
				mismatch_count++;
			end else begin
				want = motion_expected.pop_front();
				compare_field("new_pos_x", want.new_pos_x, rsp.new_pos_x);
				compare_field("new_pos_y", want.new_pos_y, rsp.new_pos_y);
				compare_field("new_heading", want.new_heading, rsp.new_heading);
				compare_field("speed_next", want.speed_next, rsp.speed_next);
				compare_field("vel_x", want.vel_x, rsp.vel_x);
				compare_field("vel_y", want.vel_y, rsp.vel_y);
			end
			checked_count++;
		end
		quiet_cycles <= (req_taken || rsp_taken) ? 0 : quiet_cycles + 1;
		// Back-pressure for the next edge
		rsp_stall <= ($urandom_range(99) < recv_idle_pct);
	end

	// Abandon the run if the handshakes stop moving
	initial begin : watchdog
		while (quiet_cycles < QUIET_LIMIT) @(posedge clk);
		$error("no transaction for %0d cycles", QUIET_LIMIT);
		$display("[FAIL] regression broken");
		$finish;
	end

	// ------------------------------------------------------------------
	// Stimulus
	// ------------------------------------------------------------------

	// Offer one request, with a random idle gap first, and hold it until taken
	task automatic send_motion(input motion_in_t item);
		while ($urandom_range(99) < send_idle_pct) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid <= 1'b1;
		req       <= item;
		@(posedge clk);
		while (req_stall) @(posedge clk);
	endtask

	task automatic test_field_extremes();
		motion_in_t m;
		// Object at rest at the origin
		m = '0;
		send_motion(m);
		// Largest positive speed, heading just short of a full turn
		m.pos_x     = 24'h7FFFFF;
		m.pos_y     = 24'h800000;
		m.heading   = 16'hFFFF;
		m.speed_now = 16'h7FFF;
		send_motion(m);
		m.pos_x     = 24'h800000;
		m.pos_y     = 24'h7FFFFF;
		m.heading   = 16'h0000;
		m.speed_now = 16'h8000;
		m.accel     = 16'h7FFF;
		send_motion(m);
		// Turn rate extremes, wrapping the heading both ways
		m           = '0;
		m.heading   = 16'h1234;
		m.turn_rate = 16'h8000;
		m.speed_now = 16'h0100;
		send_motion(m);
		m.heading   = 16'hFFFF;
		m.turn_rate = 16'h7FFF;
		send_motion(m);
		// Widest limits enabled: no effect on the speed
		m               = '0;
		m.speed_now     = 16'h0200;
		m.speed_ceiling = 16'h7FFF;
		m.speed_floor   = 16'h8000;
		m.ceiling_on    = 1'b1;
		m.floor_on      = 1'b1;
		send_motion(m);
	endtask

	task automatic test_speed_saturation();
		motion_in_t m;
		m           = '0;
		m.heading   = 16'h2000;
		m.speed_now = 16'h7FFF;
		m.accel     = 16'h7FFF;
		send_motion(m);
		m.heading   = 16'h6000;
		m.speed_now = 16'h8000;
		m.accel     = 16'h8000;
		send_motion(m);
		m.speed_now = 16'h7FFF;
		m.accel     = 16'hFFFF;
		send_motion(m);
	endtask

	task automatic test_sign_reversal();
		motion_in_t m;
		// Forward to reverse and back: heading flips
		m           = '0;
		m.heading   = 16'h0400;
		m.speed_now = 16'sd100;
		m.accel     = -16'sd300;
		send_motion(m);
		m.heading   = 16'hC000;
		m.speed_now = -16'sd100;
		m.accel     = 16'sd300;
		send_motion(m);
		// Landing on or starting from zero never flips
		m.speed_now = 16'sd100;
		m.accel     = -16'sd100;
		send_motion(m);
		m.speed_now = 16'sd0;
		m.accel     = 16'sd50;
		send_motion(m);
		m.speed_now = -16'sd1;
		m.accel     = 16'sd1;
		send_motion(m);
	endtask

	task automatic test_speed_clamps();
		motion_in_t m;
		// Ceiling alone; the disabled floor would otherwise bite
		m               = '0;
		m.heading       = 16'h1000;
		m.speed_now     = 16'sd1000;
		m.accel         = 16'sd500;
		m.speed_ceiling = 16'sd1200;
		m.speed_floor   = 16'sd3000;
		m.ceiling_on    = 1'b1;
		send_motion(m);
		// Floor alone; the disabled ceiling would otherwise bite
		m.speed_now     = -16'sd1000;
		m.accel         = -16'sd500;
		m.speed_ceiling = -16'sd3000;
		m.speed_floor   = -16'sd1200;
		m.ceiling_on    = 1'b0;
		m.floor_on      = 1'b1;
		send_motion(m);
		// Floor above ceiling with both on: floor wins
		m.speed_now     = 16'sd0;
		m.accel         = 16'sd0;
		m.speed_ceiling = -16'sd1000;
		m.speed_floor   = 16'sd1000;
		m.ceiling_on    = 1'b1;
		send_motion(m);
		// Reversal is decided on the unclamped speed
		m.speed_now     = 16'sd100;
		m.accel         = -16'sd300;
		m.speed_floor   = 16'sd50;
		m.ceiling_on    = 1'b0;
		send_motion(m);
	endtask

	task automatic test_most_negative_speed();
		motion_in_t m;
		// Magnitude 32768 saturates a positive component, fits a negative one
		m           = '0;
		m.speed_now = 16'h8000;
		send_motion(m);
		m.heading = 16'h8000;
		send_motion(m);
		m.heading = 16'h4000;
		send_motion(m);
	endtask

	task automatic test_position_saturation();
		motion_in_t m;
		m           = '0;
		m.speed_now = 16'h7FFF;
		m.pos_x     = 24'h7FFFF0;
		send_motion(m);
		m.heading = 16'h8000;
		m.pos_x   = 24'h800010;
		send_motion(m);
		m.heading = 16'h4000;
		m.pos_x   = 24'h000000;
		m.pos_y   = 24'h7FFFF0;
		send_motion(m);
		m.heading = 16'hC000;
		m.pos_y   = 24'h800010;
		send_motion(m);
	endtask

	function automatic motion_in_t random_motion();
		motion_in_t m;
		m.pos_x         = 24'($urandom);
		m.pos_y         = 24'($urandom);
		m.heading       = 16'($urandom);
		m.speed_now     = 16'($urandom);
		m.accel         = 16'($urandom);
		m.turn_rate     = 16'($urandom);
		m.speed_ceiling = 16'($urandom);
		m.speed_floor   = 16'($urandom);
		m.ceiling_on    = 1'($urandom);
		m.floor_on      = 1'($urandom);
		case ($urandom_range(4))
			0: begin
				// keep every field fully random
			end
			1: begin
				// Speeds near zero: reversals and zero crossings
				m.speed_now = 16'(int'($urandom_range(1024)) - 512);
				m.accel     = 16'(int'($urandom_range(1024)) - 512);
			end
			2: begin
				// Positions close to either edge of the range
				m.pos_x = $urandom_range(1) ? 24'h7FFFFF - 24'($urandom_range(8192))
					: 24'h800000 + 24'($urandom_range(8192));
				m.pos_y = $urandom_range(1) ? 24'h7FFFFF - 24'($urandom_range(8192))
					: 24'h800000 + 24'($urandom_range(8192));
			end
			3: begin
				// Limits set close to the new speed so they often bite
				m.speed_now     = 16'(int'($urandom_range(8192)) - 4096);
				m.accel         = 16'(int'($urandom_range(512)) - 256);
				m.speed_ceiling = m.speed_now + 16'(int'($urandom_range(1024)) - 512);
				m.speed_floor   = m.speed_now + 16'(int'($urandom_range(1024)) - 512);
			end
			default: begin
				// Ordinary motion: moderate speed, gentle steering
				m.pos_x     = 24'(int'($urandom_range(2000000)) - 1000000);
				m.pos_y     = 24'(int'($urandom_range(2000000)) - 1000000);
				m.speed_now = 16'(int'($urandom_range(4096)) - 2048);
				m.accel     = 16'(int'($urandom_range(128)) - 64);
				m.turn_rate = 16'(int'($urandom_range(1024)) - 512);
			end
		endcase
		return m;
	endfunction

	task automatic test_random_motion(int count);
		repeat (count) send_motion(random_motion());
	endtask

	// ------------------------------------------------------------------
	// Sequence
	// ------------------------------------------------------------------

	initial begin : stimulus
		arst_n        = 1'b0;
		req_valid     = 1'b0;
		req           = '0;
		// Light request gaps, heavy response back-pressure to begin with
		send_idle_pct = 14;
		recv_idle_pct = 53;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_field_extremes();
		test_speed_saturation();
		test_sign_reversal();
		test_speed_clamps();
		test_most_negative_speed();
		test_position_saturation();
		test_random_motion(200);

		// Swap the idling pattern
		send_idle_pct = 53;
		recv_idle_pct = 14;
		test_random_motion(200);

		// Full rate on both sides
		send_idle_pct = 0;
		recv_idle_pct = 0;
		test_random_motion(200);

		// Drop valid, let the last acceptance register, then drain
		req_valid <= 1'b0;
		@(posedge clk);
		while (motion_expected.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Sent %0d transactions and checked %0d results over three idling patterns.",
			accepted_count, checked_count);
		$display("Predicted %0d heading reversals, %0d clamps, %0d saturated positions.",
			reversal_count, clamp_count, pos_sat_count);
		if (mismatch_count == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule
